// File: src/tws_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the two-wire bus master sequencer.
// No dependencies; compiled first.
package tws_pkg;

   localparam int OP_W     = 4;
   localparam int BYTE_W   = 8;
   localparam int TICK_W   = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 16;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_UNIT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_TIMEOUT    = 1'd1;

   localparam logic [TICK_W-1:0] TICKS_PER_UNIT_RST = 16'd64;
   localparam logic [BYTE_W-1:0] ACK_TIMEOUT_RST    = 8'd250;

   // Command codes
   typedef enum logic [OP_W-1:0] {
      OP_TICK  = 4'd0,
      OP_START = 4'd1,
      OP_STOP  = 4'd2,
      OP_SEND  = 4'd3,
      OP_READ  = 4'd4,
      OP_ACK   = 4'd5,
      OP_NACK  = 4'd6,
      OP_WACK  = 4'd7,
      OP_FRAME = 4'd8
   } op_type;

   // Sequencer phases
   typedef enum logic [4:0] {
      PH_IDLE = 5'd0,
      PH_ST_A = 5'd1,
      PH_ST_B = 5'd2,
      PH_ST_C = 5'd3,
      PH_SP_A = 5'd4,
      PH_SP_B = 5'd5,
      PH_TX_A = 5'd6,
      PH_TX_B = 5'd7,
      PH_TX_C = 5'd8,
      PH_RX_A = 5'd9,
      PH_RX_B = 5'd10,
      PH_AK_A = 5'd11,
      PH_AK_B = 5'd12,
      PH_AK_C = 5'd13,
      PH_WA_A = 5'd14,
      PH_WA_B = 5'd15,
      PH_POLL = 5'd16
   } phase_type;

   // Frame progress: start, address byte, its ack, data byte, its ack, stop
   typedef enum logic [2:0] {
      FR_NONE  = 3'd0,
      FR_START = 3'd1,
      FR_ADDR  = 3'd2,
      FR_AACK  = 3'd3,
      FR_DATA  = 3'd4,
      FR_DACK  = 3'd5,
      FR_STOP  = 3'd6
   } frame_type;

   // Whole sequencer state
   typedef struct packed {
      phase_type         phase;
      logic [TICK_W-1:0] unit_cnt;
      logic [2:0]        wait_units;
      logic [3:0]        bit_cnt;
      logic [BYTE_W-1:0] shift_byte;
      logic [BYTE_W-1:0] second_byte;
      logic [BYTE_W-1:0] poll_cnt;
      logic              scl_lvl;
      logic              sda_lvl;
      logic [BYTE_W-1:0] read_reg;
      logic              fail;
      logic              ack_choice;
      frame_type         frame;
   } st_type;

   // Delay units of each timed phase
   function automatic logic [2:0] step_units(phase_type p);
      logic [2:0] u;
      case (p)
         PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B: u = 3'd4;
         PH_TX_A, PH_TX_B, PH_TX_C, PH_RX_A,
         PH_AK_A, PH_AK_B:                   u = 3'd2;
         PH_RX_B, PH_WA_A, PH_WA_B:          u = 3'd1;
         default:                            u = 3'd0;
      endcase
      return u;
   endfunction

endpackage

// File: src/tws_if.sv
`timescale 1ns / 1ps
// Handshake channels of the sequencer: command, result and register write.
// Depends on tws_pkg.
interface tws_req_if;
   import tws_pkg::*;
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [BYTE_W-1:0] data_byte;
   logic [BYTE_W-1:0] address_byte;
   logic              ack_after_read;
   logic              sda_in;
   modport source (output valid, operation, data_byte, address_byte, ack_after_read,
                   sda_in, input ready);
   modport sink   (input valid, operation, data_byte, address_byte, ack_after_read,
                   sda_in, output ready);
endinterface

interface tws_rsp_if;
   import tws_pkg::*;
   logic              valid;
   logic              ready;
   logic              scl;
   logic              sda_out;
   logic              busy_res;
   logic              done_res;
   logic [BYTE_W-1:0] read_data;
   logic              ack_failed;
   modport source (output valid, scl, sda_out, busy_res, done_res, read_data, ack_failed,
                   input ready);
   modport sink   (input valid, scl, sda_out, busy_res, done_res, read_data, ack_failed,
                   output ready);
endinterface

interface tws_csr_if;
   import tws_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: src/two_wire_master_sequencer.sv
`timescale 1ns / 1ps
// Two-wire bus master sequencer: next-state logic, state and result registers.
// Depends on tws_pkg and the channels in tws_if.
//
// Each command word is one bus tick and yields one result word with the SCL
// and SDA levels, busy, done, the last read byte and the ack-failure flag.
// A word is taken every clock cycle: the whole sequencer step is one pass of
// logic from the state registers into the state and result registers, and
// the next word is accepted while a result still waits, as long as the result
// register is empty or is being drained in that cycle. Commands are only
// acted on while idle. Delays count in units of ticks_per_unit words; a
// wait-ack fails after more than ack_timeout polls with SDA high. Register
// writes are always accepted and should be made while the block is idle.
module two_wire_master_sequencer (
   input  logic      clock,
   input  logic      reset,
   tws_req_if.sink   req_ch,
   tws_rsp_if.source rsp_ch,
   tws_csr_if.sink   csr_ch
);
   import tws_pkg::*;

   st_type            st_ff, st_in;
   logic [TICK_W-1:0] ticks_per_unit_ff;
   logic [BYTE_W-1:0] ack_timeout_ff;
   logic              rsp_valid_ff;
   logic              done_in, done_ff;
   logic              take;

   // Enter a phase: set its line levels and restart the delay count
   function automatic st_type enter_f(st_type s, phase_type p, logic smp);
      st_type r;
      r = s;
      r.phase = p;
      r.unit_cnt = '0;
      r.wait_units = '0;
      case (p)
         PH_ST_A: begin r.scl_lvl = 1'b1; r.sda_lvl = 1'b1; end
         PH_ST_B: r.sda_lvl = 1'b0;
         PH_ST_C: r.scl_lvl = 1'b0;
         PH_SP_A: begin r.scl_lvl = 1'b0; r.sda_lvl = 1'b0; end
         PH_SP_B: begin r.scl_lvl = 1'b1; r.sda_lvl = 1'b1; end
         PH_TX_A: begin
            r.scl_lvl = 1'b0;
            r.sda_lvl = s.shift_byte[BYTE_W-1];
            r.shift_byte = {s.shift_byte[BYTE_W-2:0], 1'b0};
            r.bit_cnt = s.bit_cnt + 4'd1;
         end
         PH_TX_B: r.scl_lvl = 1'b1;
         PH_TX_C: r.scl_lvl = 1'b0;
         PH_RX_A: begin r.scl_lvl = 1'b0; r.sda_lvl = 1'b1; end
         PH_RX_B: begin
            r.scl_lvl = 1'b1;
            r.shift_byte = {s.shift_byte[BYTE_W-2:0], smp};
            r.bit_cnt = s.bit_cnt + 4'd1;
         end
         PH_AK_A: begin r.scl_lvl = 1'b0; r.sda_lvl = ~s.ack_choice; end
         PH_AK_B: r.scl_lvl = 1'b1;
         PH_AK_C: r.scl_lvl = 1'b0;
         PH_WA_A: r.sda_lvl = 1'b1;
         PH_WA_B: r.scl_lvl = 1'b1;
         PH_POLL: r.poll_cnt = '0;
         default: r.phase = PH_IDLE;
      endcase
      return r;
   endfunction

   // End of a segment: move on through a frame, or finish
   function automatic st_type seg_done_f(st_type s, output logic done);
      st_type r;
      r = s;
      done = 1'b0;
      case (s.frame)
         FR_START: begin
            r.frame = FR_ADDR; r.bit_cnt = '0; r = enter_f(r, PH_TX_A, 1'b0);
         end
         FR_ADDR: begin r.frame = FR_AACK; r = enter_f(r, PH_AK_A, 1'b0); end
         FR_AACK: begin
            r.frame = FR_DATA; r.shift_byte = s.second_byte; r.bit_cnt = '0;
            r = enter_f(r, PH_TX_A, 1'b0);
         end
         FR_DATA: begin r.frame = FR_DACK; r = enter_f(r, PH_AK_A, 1'b0); end
         FR_DACK: begin r.frame = FR_STOP; r = enter_f(r, PH_SP_A, 1'b0); end
         default: begin
            r.frame = FR_NONE; r.phase = PH_IDLE;
            r.unit_cnt = '0; r.wait_units = '0;
            done = 1'b1;
         end
      endcase
      return r;
   endfunction

   // A timed phase ran out
   function automatic st_type phase_end_f(st_type s, logic smp, output logic done);
      st_type r;
      r = s;
      done = 1'b0;
      case (s.phase)
         PH_ST_A: r = enter_f(s, PH_ST_B, 1'b0);
         PH_ST_B: r = enter_f(s, PH_ST_C, 1'b0);
         PH_SP_A: r = enter_f(s, PH_SP_B, 1'b0);
         PH_TX_A: r = enter_f(s, PH_TX_B, 1'b0);
         PH_TX_B: r = enter_f(s, PH_TX_C, 1'b0);
         PH_TX_C: begin
            if (s.bit_cnt < 4'd8) begin
               r = enter_f(s, PH_TX_A, 1'b0);
            end else begin
               r = seg_done_f(s, done);
            end
         end
         PH_RX_A: r = enter_f(s, PH_RX_B, smp);
         PH_RX_B: begin
            if (s.bit_cnt < 4'd8) begin
               r = enter_f(s, PH_RX_A, 1'b0);
            end else begin
               r.read_reg = s.shift_byte;
               r = enter_f(r, PH_AK_A, 1'b0);
            end
         end
         PH_AK_A: r = enter_f(s, PH_AK_B, 1'b0);
         PH_AK_B: r = enter_f(s, PH_AK_C, 1'b0);
         PH_WA_A: r = enter_f(s, PH_WA_B, 1'b0);
         PH_WA_B: r = enter_f(s, PH_POLL, 1'b0);
         default: r = seg_done_f(s, done);
      endcase
      return r;
   endfunction

   // Handshakes: a word is taken when the result register is free or draining
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign take         = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   // One sequencer step
   always_comb begin
      st_type            s;
      logic [TICK_W-1:0] cnt;
      logic [2:0]        units;
      logic [BYTE_W:0]   polls;
      logic              ended;
      s       = st_ff;
      done_in = 1'b0;
      cnt     = st_ff.unit_cnt + 16'd1;
      units   = st_ff.wait_units + 3'd1;
      polls   = {1'b0, st_ff.poll_cnt} + 9'd1;
      ended   = 1'b0;
      case (st_ff.phase)
         PH_IDLE: begin
            s.frame = FR_NONE;
            case (req_ch.operation)
               OP_START: s = enter_f(s, PH_ST_A, 1'b0);
               OP_STOP:  s = enter_f(s, PH_SP_A, 1'b0);
               OP_SEND: begin
                  s.shift_byte = req_ch.data_byte; s.bit_cnt = '0;
                  s = enter_f(s, PH_TX_A, 1'b0);
               end
               OP_READ: begin
                  s.ack_choice = req_ch.ack_after_read; s.shift_byte = '0;
                  s.bit_cnt = '0;
                  s = enter_f(s, PH_RX_A, 1'b0);
               end
               OP_ACK:  begin s.ack_choice = 1'b1; s = enter_f(s, PH_AK_A, 1'b0); end
               OP_NACK: begin s.ack_choice = 1'b0; s = enter_f(s, PH_AK_A, 1'b0); end
               OP_WACK: begin s.fail = 1'b0; s = enter_f(s, PH_WA_A, 1'b0); end
               OP_FRAME: begin
                  s.shift_byte = req_ch.address_byte; s.second_byte = req_ch.data_byte;
                  s.ack_choice = 1'b1; s.frame = FR_START;
                  s = enter_f(s, PH_ST_A, 1'b0);
               end
               default: ;
            endcase
         end
         PH_POLL: begin
            if (!req_ch.sda_in) begin
               s.scl_lvl = 1'b0;
               s = seg_done_f(s, done_in);
            end else if (polls > {1'b0, ack_timeout_ff}) begin
               s.fail = 1'b1; s.frame = FR_NONE;
               s = enter_f(s, PH_SP_A, 1'b0);
            end else begin
               s.poll_cnt = polls[BYTE_W-1:0];
            end
         end
         default: begin
            if (step_units(st_ff.phase) == 3'd0) begin
               ended = 1'b1;
            end else begin
               s.unit_cnt = cnt;
               if (cnt >= ticks_per_unit_ff) begin
                  s.unit_cnt = '0;
                  s.wait_units = units;
                  ended = (units >= step_units(st_ff.phase));
               end
            end
            if (ended) begin
               s = phase_end_f(s, req_ch.sda_in, done_in);
            end
         end
      endcase
      st_in = s;
   end

   // State, configuration and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff             <= '{phase: PH_IDLE, frame: FR_NONE, scl_lvl: 1'b1,
                                sda_lvl: 1'b1, default: '0};
         ticks_per_unit_ff <= TICKS_PER_UNIT_RST;
         ack_timeout_ff    <= ACK_TIMEOUT_RST;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (take) begin
            st_ff <= st_in;
         end
         if (csr_ch.valid) begin
            case (csr_ch.index)
               CSR_TICKS_PER_UNIT: ticks_per_unit_ff <= csr_ch.data[TICK_W-1:0];
               CSR_ACK_TIMEOUT:    ack_timeout_ff    <= csr_ch.data[BYTE_W-1:0];
               default: ;
            endcase
         end
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Done pulse belongs to the result word
   always_ff @(posedge clock) begin
      if (take) begin
         done_ff <= done_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.scl        = st_ff.scl_lvl;
   assign rsp_ch.sda_out    = st_ff.sda_lvl;
   assign rsp_ch.busy_res   = (st_ff.phase != PH_IDLE);
   assign rsp_ch.done_res   = done_ff;
   assign rsp_ch.read_data  = st_ff.read_reg;
   assign rsp_ch.ack_failed = st_ff.fail;

endmodule

// File: bench/two_wire_master_sequencer_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the two-wire bus master sequencer: directed and random
// tick words, a local bus predictor and field-by-field result checks.
// Depends on tws_pkg, the channels in tws_if and two_wire_master_sequencer.
module two_wire_master_sequencer_tb;
   import tws_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int HOLD_CYCLES = 300;

   // One command word and one line-level result word
   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [BYTE_W-1:0] data;
      logic [BYTE_W-1:0] addr;
      logic              ack_rd;
      logic              sda;
   } cmd_word_type;

   typedef struct packed {
      logic              scl;
      logic              sda;
      logic              busy;
      logic              done;
      logic [BYTE_W-1:0] rd;
      logic              fail;
   } line_word_type;

   logic clock;
   logic reset;

   tws_req_if req_ch ();
   tws_rsp_if rsp_ch ();
   tws_csr_if csr_ch ();

   two_wire_master_sequencer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Words waiting to be offered, and line levels still to come back
   cmd_word_type  tick_words_q [$];
   line_word_type line_levels_q [$];

   int          src_idle = 0;
   int          rsp_stall = 0;
   logic        hold_rsp = 1'b0;
   int unsigned cycle_cnt = 0;
   int          errors = 0;
   int          words_checked = 0;
   int          ops_finished = 0;
   int          ack_timeouts = 0;

   // Predictor copy of the registers and the sequencer state
   logic [TICK_W-1:0] tick_div;
   logic [BYTE_W-1:0] poll_limit;
   phase_type         bus_phase;
   frame_type         frame_st;
   logic [TICK_W-1:0] unit_cnt;
   logic [2:0]        units_done;
   logic [3:0]        bits_done;
   logic [BYTE_W-1:0] shreg;
   logic [BYTE_W-1:0] data_hold;
   logic [BYTE_W-1:0] polls;
   logic              scl_q;
   logic              sda_q;
   logic [BYTE_W-1:0] rd_byte;
   logic              ack_fail;
   logic              send_ack;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [2:0] phase_units(phase_type p);
      case (p)
         PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B: return 3'd4;
         PH_TX_A, PH_TX_B, PH_TX_C, PH_RX_A,
         PH_AK_A, PH_AK_B:                   return 3'd2;
         PH_RX_B, PH_WA_A, PH_WA_B:          return 3'd1;
         default:                            return 3'd0;
      endcase
   endfunction

   task automatic clear_bus_state();
      tick_div   = TICKS_PER_UNIT_RST;
      poll_limit = ACK_TIMEOUT_RST;
      bus_phase  = PH_IDLE;
      frame_st   = FR_NONE;
      unit_cnt   = '0;
      units_done = '0;
      bits_done  = '0;
      shreg      = '0;
      data_hold  = '0;
      polls      = '0;
      scl_q      = 1'b1;
      sda_q      = 1'b1;
      rd_byte    = '0;
      ack_fail   = 1'b0;
      send_ack   = 1'b0;
   endtask

   // Entering a phase sets its line levels at once
   task automatic enter_phase(phase_type p, logic sample);
      bus_phase  = p;
      unit_cnt   = '0;
      units_done = '0;
      case (p)
         PH_ST_A: begin
            scl_q = 1'b1;
            sda_q = 1'b1;
         end
         PH_ST_B: sda_q = 1'b0;
         PH_ST_C: scl_q = 1'b0;
         PH_SP_A: begin
            scl_q = 1'b0;
            sda_q = 1'b0;
         end
         PH_SP_B: begin
            scl_q = 1'b1;
            sda_q = 1'b1;
         end
         PH_TX_A: begin
            scl_q     = 1'b0;
            sda_q     = shreg[7];
            shreg     = {shreg[6:0], 1'b0};
            bits_done = bits_done + 4'd1;
         end
         PH_TX_B: scl_q = 1'b1;
         PH_TX_C: scl_q = 1'b0;
         PH_RX_A: begin
            scl_q = 1'b0;
            sda_q = 1'b1;
         end
         PH_RX_B: begin
            scl_q     = 1'b1;
            shreg     = {shreg[6:0], sample};
            bits_done = bits_done + 4'd1;
         end
         PH_AK_A: begin
            scl_q = 1'b0;
            sda_q = !send_ack;
         end
         PH_AK_B: scl_q = 1'b1;
         PH_AK_C: scl_q = 1'b0;
         PH_WA_A: sda_q = 1'b1;
         PH_WA_B: scl_q = 1'b1;
         PH_POLL: polls = '0;
         default: bus_phase = PH_IDLE;
      endcase
   endtask

   // A segment is over: carry on with the frame, or finish the operation
   task automatic segment_end(output logic fin);
      fin = 1'b0;
      case (frame_st)
         FR_START: begin
            frame_st  = FR_ADDR;
            bits_done = '0;
            enter_phase(PH_TX_A, 1'b0);
         end
         FR_ADDR: begin
            frame_st = FR_AACK;
            enter_phase(PH_AK_A, 1'b0);
         end
         FR_AACK: begin
            frame_st  = FR_DATA;
            shreg     = data_hold;
            bits_done = '0;
            enter_phase(PH_TX_A, 1'b0);
         end
         FR_DATA: begin
            frame_st = FR_DACK;
            enter_phase(PH_AK_A, 1'b0);
         end
         FR_DACK: begin
            frame_st = FR_STOP;
            enter_phase(PH_SP_A, 1'b0);
         end
         default: begin
            frame_st   = FR_NONE;
            bus_phase  = PH_IDLE;
            unit_cnt   = '0;
            units_done = '0;
            fin        = 1'b1;
         end
      endcase
   endtask

   task automatic phase_end(logic sample, output logic fin);
      fin = 1'b0;
      case (bus_phase)
         PH_ST_A: enter_phase(PH_ST_B, 1'b0);
         PH_ST_B: enter_phase(PH_ST_C, 1'b0);
         PH_SP_A: enter_phase(PH_SP_B, 1'b0);
         PH_TX_A: enter_phase(PH_TX_B, 1'b0);
         PH_TX_B: enter_phase(PH_TX_C, 1'b0);
         PH_TX_C: begin
            if (bits_done < 4'd8) enter_phase(PH_TX_A, 1'b0);
            else segment_end(fin);
         end
         PH_RX_A: enter_phase(PH_RX_B, sample);
         PH_RX_B: begin
            if (bits_done < 4'd8) begin
               enter_phase(PH_RX_A, 1'b0);
            end else begin
               rd_byte = shreg;
               enter_phase(PH_AK_A, 1'b0);
            end
         end
         PH_AK_A: enter_phase(PH_AK_B, 1'b0);
         PH_AK_B: enter_phase(PH_AK_C, 1'b0);
         PH_WA_A: enter_phase(PH_WA_B, 1'b0);
         PH_WA_B: enter_phase(PH_POLL, 1'b0);
         default: segment_end(fin);
      endcase
   endtask

   // One bus tick: advance the sequencer and give the expected line levels
   task automatic sequencer_tick(input cmd_word_type w, output line_word_type r);
      logic       fin;
      logic       ended;
      logic [2:0] need;
      logic [8:0] n;
      fin   = 1'b0;
      ended = 1'b0;
      if (bus_phase == PH_IDLE) begin
         frame_st = FR_NONE;
         case (w.op)
            OP_START: enter_phase(PH_ST_A, 1'b0);
            OP_STOP:  enter_phase(PH_SP_A, 1'b0);
            OP_SEND: begin
               shreg     = w.data;
               bits_done = '0;
               enter_phase(PH_TX_A, 1'b0);
            end
            OP_READ: begin
               send_ack  = w.ack_rd;
               shreg     = '0;
               bits_done = '0;
               enter_phase(PH_RX_A, 1'b0);
            end
            OP_ACK: begin
               send_ack = 1'b1;
               enter_phase(PH_AK_A, 1'b0);
            end
            OP_NACK: begin
               send_ack = 1'b0;
               enter_phase(PH_AK_A, 1'b0);
            end
            OP_WACK: begin
               ack_fail = 1'b0;
               enter_phase(PH_WA_A, 1'b0);
            end
            OP_FRAME: begin
               shreg     = w.addr;
               data_hold = w.data;
               send_ack  = 1'b1;
               frame_st  = FR_START;
               enter_phase(PH_ST_A, 1'b0);
            end
            default: ;
         endcase
      end else if (bus_phase == PH_POLL) begin
         // slave pulls data low: ack seen; else count a poll, or time out past the limit
         if (!w.sda) begin
            scl_q = 1'b0;
            segment_end(fin);
         end else begin
            n = {1'b0, polls} + 9'd1;
            if (n > {1'b0, poll_limit}) begin
               ack_fail = 1'b1;
               frame_st = FR_NONE;
               ack_timeouts++;
               enter_phase(PH_SP_A, 1'b0);
            end else begin
               polls = n[7:0];
            end
         end
      end else begin
         need = phase_units(bus_phase);
         if (need == 3'd0) begin
            ended = 1'b1;
         end else begin
            unit_cnt = unit_cnt + 1'b1;
            if (unit_cnt >= tick_div) begin
               unit_cnt   = '0;
               units_done = units_done + 3'd1;
               if (units_done >= need) ended = 1'b1;
            end
         end
         if (ended) phase_end(w.sda, fin);
      end
      if (fin) ops_finished++;
      r.scl  = scl_q;
      r.sda  = sda_q;
      r.busy = (bus_phase != PH_IDLE);
      r.done = fin;
      r.rd   = rd_byte;
      r.fail = ack_fail;
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin : drive_cmds
      line_word_type r;
      cmd_word_type  w;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            sequencer_tick(tick_words_q.pop_front(), r);
            line_levels_q.push_back(r);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (tick_words_q.size() != 0 &&
                (src_idle == 0 || $urandom_range(99) >= src_idle)) begin
               w = tick_words_q[0];
               req_ch.valid          <= 1'b1;
               req_ch.operation      <= w.op;
               req_ch.data_byte      <= w.data;
               req_ch.address_byte   <= w.addr;
               req_ch.ack_after_read <= w.ack_rd;
               req_ch.sda_in         <= w.sda;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      errors++;
      $display("MISMATCH word %0d %s: got %0h, expected %0h",
               words_checked, what, got, want);
   endtask

   task automatic check_field(string what, logic [7:0] got, logic [7:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   always @(posedge clock) begin : watch_levels
      line_word_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            words_checked++;
            if (line_levels_q.size() == 0) begin
               report_mismatch("result word with no command behind it", 8'h0, 8'h0);
            end else begin
               want = line_levels_q.pop_front();
               check_field("scl", 8'(rsp_ch.scl), 8'(want.scl));
               check_field("sda_out", 8'(rsp_ch.sda_out), 8'(want.sda));
               check_field("busy_res", 8'(rsp_ch.busy_res), 8'(want.busy));
               check_field("done_res", 8'(rsp_ch.done_res), 8'(want.done));
               check_field("read_data", rsp_ch.read_data, want.rd);
               check_field("ack_failed", 8'(rsp_ch.ack_failed), 8'(want.fail));
            end
         end
         rsp_ch.ready <= !hold_rsp && (rsp_stall == 0 || $urandom_range(99) >= rsp_stall);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles, %0d words still expected",
                  cycle_cnt, line_levels_q.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic push_word(logic [OP_W-1:0] op, logic [7:0] data, logic [7:0] addr,
                            logic ack_rd, logic sda);
      cmd_word_type w;
      w.op     = op;
      w.data   = data;
      w.addr   = addr;
      w.ack_rd = ack_rd;
      w.sda    = sda;
      tick_words_q.push_back(w);
   endtask

   // Filler tick: no command, or an unused code; sda 0, 1 or random (2)
   task automatic push_filler(int sda_mode);
      logic [OP_W-1:0] op;
      op = $urandom_range(1) ? OP_TICK : OP_W'($urandom_range(15, 9));
      push_word(op, 8'($urandom_range(255)), 8'($urandom_range(255)),
                1'($urandom_range(1)),
                sda_mode == 2 ? 1'($urandom_range(1)) : sda_mode[0]);
   endtask

   // Wait for every word to return, feeding filler ticks until the bus is idle
   task automatic settle(int sda_mode);
      logic running;
      running = 1'b1;
      @(negedge clock);
      while (running) begin
         while (tick_words_q.size() != 0 || line_levels_q.size() != 0) @(negedge clock);
         if (bus_phase == PH_IDLE) running = 1'b0;
         else repeat (tick_div > 64 ? 1024 : 32) push_filler(sda_mode);
      end
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] val);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      if (idx == CSR_TICKS_PER_UNIT) tick_div = val;
      else poll_limit = val[7:0];
      @(negedge clock);
   endtask

   // Mixed stream: mostly plain ticks and commands, some unused codes
   task automatic random_burst(int n, int sda_hi);
      int              r;
      logic [OP_W-1:0] op;
      repeat (n) begin
         r = $urandom_range(99);
         if (r < 55) op = OP_TICK;
         else if (r < 90) op = OP_W'($urandom_range(8, 1));
         else op = OP_W'($urandom_range(15, 9));
         push_word(op, 8'($urandom_range(255)), 8'($urandom_range(255)),
                   1'($urandom_range(1)), $urandom_range(99) < sda_hi);
      end
   endtask

   initial begin
      reset = 1'b1;
      clear_bus_state();
      csr_ch.valid          <= 1'b0;
      csr_ch.index          <= '0;
      csr_ch.data           <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part at one tick per unit
      write_reg(CSR_TICKS_PER_UNIT, 16'd1);
      write_reg(CSR_ACK_TIMEOUT, 16'd3);
      push_word(OP_TICK, 8'hFF, 8'hFF, 1'b1, 1'b1);
      for (int c = 9; c <= 15; c++) push_word(OP_W'(c), 8'hFF, 8'h00, 1'b1, 1'b0);
      settle(2);
      push_word(OP_START, 8'h00, 8'h00, 1'b0, 1'b1);
      settle(2);
      push_word(OP_STOP, 8'hFF, 8'hFF, 1'b1, 1'b0);
      settle(2);
      push_word(OP_SEND, 8'hFF, 8'h00, 1'b0, 1'b0);
      settle(2);
      push_word(OP_SEND, 8'h00, 8'hFF, 1'b1, 1'b1);
      settle(2);
      // a start landing on the tick that reports done must be dropped
      push_word(OP_SEND, 8'hA5, 8'h5A, 1'b0, 1'b0);
      repeat (47) push_word(OP_TICK, 8'h00, 8'h00, 1'b0, 1'b0);
      push_word(OP_START, 8'h00, 8'h00, 1'b0, 1'b0);
      settle(2);
      push_word(OP_READ, 8'h00, 8'h00, 1'b1, 1'b1);
      settle(1);
      push_word(OP_READ, 8'h00, 8'h00, 1'b0, 1'b0);
      settle(0);
      push_word(OP_READ, 8'h00, 8'h00, 1'b1, 1'b0);
      settle(2);
      push_word(OP_ACK, 8'h00, 8'h00, 1'b0, 1'b1);
      settle(2);
      push_word(OP_NACK, 8'h00, 8'h00, 1'b1, 1'b1);
      settle(2);
      // wait-ack: quick ack, then timeout with stop, then flag cleared again
      push_word(OP_WACK, 8'h00, 8'h00, 1'b0, 1'b0);
      settle(0);
      push_word(OP_WACK, 8'h00, 8'h00, 1'b0, 1'b1);
      settle(1);
      push_word(OP_WACK, 8'h00, 8'h00, 1'b0, 1'b1);
      settle(0);
      // frames, with commands thrown in while busy
      push_word(OP_FRAME, 8'h00, 8'hFF, 1'b0, 1'b1);
      push_word(OP_START, 8'h00, 8'h00, 1'b0, 1'b1);
      push_word(OP_READ, 8'h00, 8'h00, 1'b1, 1'b0);
      push_word(OP_WACK, 8'h00, 8'h00, 1'b0, 1'b0);
      push_word(OP_FRAME, 8'h12, 8'h34, 1'b1, 1'b1);
      settle(2);
      push_word(OP_FRAME, 8'hFF, 8'h00, 1'b1, 1'b0);
      settle(2);

      // No idling; receiver held off for a long stretch while words keep coming
      write_reg(CSR_ACK_TIMEOUT, 16'd1);
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp <= 1'b0;
         end
      join_none
      random_burst(200, 50);
      settle(2);

      // Sender idle; zero tick unit and zero poll allowance
      src_idle = 78;
      write_reg(CSR_TICKS_PER_UNIT, 16'd0);
      write_reg(CSR_ACK_TIMEOUT, 16'd0);
      random_burst(200, 50);
      settle(2);

      // Receiver stalling; full poll allowance, data mostly high
      src_idle  = 0;
      rsp_stall = 78;
      write_reg(CSR_TICKS_PER_UNIT, 16'd2);
      write_reg(CSR_ACK_TIMEOUT, 16'h00FF);
      random_burst(200, 90);
      settle(2);

      // Both sides idling; upper data bits on the timeout register are dropped
      src_idle  = 26;
      rsp_stall = 26;
      write_reg(CSR_TICKS_PER_UNIT, 16'd3);
      write_reg(CSR_ACK_TIMEOUT, 16'hA505);
      random_burst(200, 70);
      settle(2);

      // A longer tick unit: one wait-ack, acked on the first poll
      src_idle  = 0;
      rsp_stall = 0;
      write_reg(CSR_TICKS_PER_UNIT, 16'd48);
      write_reg(CSR_ACK_TIMEOUT, 16'd250);
      push_word(OP_WACK, 8'hC3, 8'h3C, 1'b1, 1'b1);
      settle(0);

      repeat (8) @(posedge clock);
      if (line_levels_q.size() != 0)
         report_mismatch("result words never returned", 8'(line_levels_q.size()), 8'h0);
      $display("Checked %0d bus ticks at tick units 0 to 48 and poll limits 0 to 255,",
               words_checked);
      $display("with %0d operations finished and %0d wait-ack timeouts; %0d mismatches.",
               ops_finished, ack_timeouts, errors);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/tws_pkg.sv
src/tws_if.sv
src/two_wire_master_sequencer.sv
bench/two_wire_master_sequencer_tb.sv
